// ===== sv/axi4_burst_memory_slave_assert.svh =====
// Assertion macros for the burst memory slave.
`ifndef AXI4_BURST_MEMORY_SLAVE_ASSERT_SVH
`define AXI4_BURST_MEMORY_SLAVE_ASSERT_SVH
`ifndef SYNTHESIS
`define ABMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ABMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ABMS_ASSERT_IMP(lbl, ante, cons, msg)
`define ABMS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/abms_pkg.sv =====
// Shared constants, types and helpers for the burst memory slave.
package abms_pkg;

  localparam int unsigned MEM_BYTES = 65536;
  localparam logic [31:0] MEM_BASE  = 32'h8000_0000;
  localparam int unsigned BANKS     = 8;
  localparam int unsigned OFF_W     = $clog2(MEM_BYTES);
  localparam int unsigned ROW_W     = OFF_W - 3;
  localparam int unsigned ROWS      = MEM_BYTES / BANKS;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_RADDR = 3'd1;
  localparam logic [2:0] PH_RDATA = 3'd2;
  localparam logic [2:0] PH_WADDR = 3'd3;
  localparam logic [2:0] PH_WDATA = 3'd4;
  localparam logic [2:0] PH_WACK  = 3'd5;

  localparam logic [1:0] RESP_OKAY = 2'b00;
  localparam logic [3:0] BID_WRITE = 4'd1;
  localparam logic [1:0] BEAT_SIZE_RESET = 2'd3;

  // One beat access to the banked byte store.
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic             win;
    logic [OFF_W-1:0] off;
    logic [63:0]      data;
    logic [7:0]       strb;
  } mem_req_t;

  function automatic logic in_window(input logic [31:0] a);
    logic [32:0] lim;
    lim = 33'(MEM_BASE) + 33'(MEM_BYTES);
    return (a != 32'd0) && (a >= MEM_BASE) && ((33'(a) + 33'd8) < lim);
  endfunction

endpackage

// ===== sv/abms_if.sv =====
// Request and response channel interfaces of the burst memory slave.
interface abms_req_if;
  logic        valid;
  logic        ready;
  logic        aw_valid;
  logic [31:0] aw_addr;
  logic [7:0]  aw_len;
  logic        ar_valid;
  logic [31:0] ar_addr;
  logic [7:0]  ar_len;
  logic        w_valid;
  logic [63:0] w_data;
  logic [7:0]  w_strb;
  logic        r_ready;
  logic        b_ready;

  modport source (output valid, aw_valid, aw_addr, aw_len, ar_valid, ar_addr, ar_len,
                  w_valid, w_data, w_strb, r_ready, b_ready, input ready);
  modport sink (input valid, aw_valid, aw_addr, aw_len, ar_valid, ar_addr, ar_len,
                w_valid, w_data, w_strb, r_ready, b_ready, output ready);
endinterface

interface abms_rsp_if;
  logic        valid;
  logic        ready;
  logic        aw_ready;
  logic        ar_ready;
  logic        w_ready;
  logic        b_valid;
  logic [1:0]  b_resp;
  logic [3:0]  b_id;
  logic        r_valid;
  logic [63:0] r_data;
  logic [1:0]  r_resp;
  logic        r_last;

  modport source (output valid, aw_ready, ar_ready, w_ready, b_valid, b_resp, b_id,
                  r_valid, r_data, r_resp, r_last, input ready);
  modport sink (input valid, aw_ready, ar_ready, w_ready, b_valid, b_resp, b_id,
                r_valid, r_data, r_resp, r_last, output ready);
endinterface

// ===== sv/axi4_burst_memory_slave.sv =====
// Top level of the burst memory slave: handshake sequencer and burst state.
// Each request transfer is one sampled bus clock of master signals; each
// response transfer is the slave's driven signals after that clock. A request
// is accepted in S_IN and its response presented from S_OUT; a read beat passes
// through S_LOAD in between, since the banked byte store has a registered read;
// response stalls hold S_OUT. One request is in flight at a time. The store is
// eight byte-wide banks, so any unaligned beat of up to eight bytes is one
// access; store bytes read before they were ever written return undefined data.
`include "axi4_burst_memory_slave_assert.svh"
module axi4_burst_memory_slave import abms_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_wr_data,
  abms_req_if.sink        req,
  abms_rsp_if.source      rsp
);

  localparam logic [1:0] S_IN   = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]  seq;
  logic [1:0]  beat_size_log2;
  logic [2:0]  phase, phase_next;
  logic [8:0]  beats_left, beats_left_next;
  logic [7:0]  beat_index, beat_index_next;
  logic [31:0] burst_base, burst_base_next;
  logic [63:0] output_hold;
  logic        aw_rdy_q, aw_rdy_next;
  logic        ar_rdy_q, ar_rdy_next;
  logic        w_rdy_q, w_rdy_next;
  logic        b_vld_q, b_vld_next;
  logic        r_vld_q, r_vld_next;
  logic        r_last_q, r_last_next;
  logic [3:0]  bid_q, bid_next;

  logic        accept;
  logic [31:0] beat_addr;
  logic [8:0]  bl_dec;
  mem_req_t    mem_req;
  logic [63:0] mem_rdata;

  assign accept    = req.valid && req.ready;
  assign req.ready = (seq == S_IN);
  assign beat_addr = burst_base + (32'(beat_index) << beat_size_log2);
  assign bl_dec    = (beats_left != 9'd0) ? beats_left - 9'd1 : 9'd0;

  always_comb begin
    phase_next      = phase;
    beats_left_next = beats_left;
    beat_index_next = beat_index;
    burst_base_next = burst_base;
    aw_rdy_next     = aw_rdy_q;
    ar_rdy_next     = ar_rdy_q;
    w_rdy_next      = w_rdy_q;
    b_vld_next      = b_vld_q;
    r_vld_next      = r_vld_q;
    r_last_next     = r_last_q;
    bid_next        = bid_q;
    mem_req.rd      = 1'b0;
    mem_req.wr      = 1'b0;
    mem_req.win     = in_window(beat_addr);
    mem_req.off     = OFF_W'(beat_addr - MEM_BASE);
    mem_req.data    = req.w_data;
    mem_req.strb    = req.w_strb;
    case (phase)
      PH_RADDR: begin
        ar_rdy_next     = 1'b1;
        beats_left_next = 9'(req.ar_len) + 9'd1;
        burst_base_next = req.ar_addr;
        phase_next      = PH_RDATA;
      end
      PH_RDATA: begin
        r_vld_next = 1'b1;
        mem_req.rd = accept;
        if (req.r_ready) begin
          beats_left_next = bl_dec;
          if (bl_dec != 9'd0) begin
            beat_index_next = beat_index + 8'd1;
            r_last_next     = 1'b0;
          end else begin
            r_last_next     = 1'b1;
            beat_index_next = 8'd0;
            phase_next      = PH_IDLE;
          end
        end
      end
      PH_WADDR: begin
        aw_rdy_next     = 1'b1;
        beats_left_next = 9'(req.aw_len) + 9'd1;
        burst_base_next = req.aw_addr;
        phase_next      = PH_WDATA;
      end
      PH_WDATA: begin
        w_rdy_next = 1'b1;
        if (req.w_valid) begin
          mem_req.wr      = accept;
          beats_left_next = bl_dec;
          if (bl_dec == 9'd0) begin
            beat_index_next = 8'd0;
            phase_next      = PH_WACK;
          end else begin
            beat_index_next = beat_index + 8'd1;
          end
        end
      end
      PH_WACK: begin
        b_vld_next = 1'b1;
        bid_next   = BID_WRITE;
        if (req.b_ready) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        // Unused codes behave as idle: drop all handshake flags.
        aw_rdy_next = 1'b0;
        ar_rdy_next = 1'b0;
        w_rdy_next  = 1'b0;
        b_vld_next  = 1'b0;
        r_vld_next  = 1'b0;
        r_last_next = 1'b0;
        if (req.aw_valid) begin
          phase_next = PH_WADDR;
        end else if (req.ar_valid) begin
          phase_next = PH_RADDR;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  abms_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .size  (beat_size_log2),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq            <= S_IN;
      beat_size_log2 <= BEAT_SIZE_RESET;
      phase          <= PH_IDLE;
      beats_left     <= 9'd0;
      beat_index     <= 8'd0;
      burst_base     <= 32'd0;
      output_hold    <= 64'd0;
      aw_rdy_q       <= 1'b0;
      ar_rdy_q       <= 1'b0;
      w_rdy_q        <= 1'b0;
      b_vld_q        <= 1'b0;
      r_vld_q        <= 1'b0;
      r_last_q       <= 1'b0;
      bid_q          <= 4'd0;
    end else begin
      if (cfg_wr_en) begin
        beat_size_log2 <= cfg_wr_data;
      end
      case (seq)
        S_IN: begin
          if (accept) begin
            phase      <= phase_next;
            beats_left <= beats_left_next;
            beat_index <= beat_index_next;
            burst_base <= burst_base_next;
            aw_rdy_q   <= aw_rdy_next;
            ar_rdy_q   <= ar_rdy_next;
            w_rdy_q    <= w_rdy_next;
            b_vld_q    <= b_vld_next;
            r_vld_q    <= r_vld_next;
            r_last_q   <= r_last_next;
            bid_q      <= bid_next;
            // Read beats pass through S_LOAD to capture the bank data.
            seq        <= mem_req.rd ? S_LOAD : S_OUT;
          end
        end
        S_LOAD: begin
          output_hold <= mem_rdata;
          seq         <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            seq <= S_IN;
          end
        end
        default: begin
          seq <= S_IN;
        end
      endcase
    end
  end

  assign rsp.valid    = (seq == S_OUT);
  assign rsp.aw_ready = aw_rdy_q;
  assign rsp.ar_ready = ar_rdy_q;
  assign rsp.w_ready  = w_rdy_q;
  assign rsp.b_valid  = b_vld_q;
  assign rsp.b_resp   = RESP_OKAY;
  assign rsp.b_id     = bid_q;
  assign rsp.r_valid  = r_vld_q;
  assign rsp.r_data   = output_hold;
  assign rsp.r_resp   = RESP_OKAY;
  assign rsp.r_last   = r_last_q;

  `ABMS_ASSERT_IMP(a_one_in_flight, 1'b1, !(req.ready && rsp.valid), "overlapping transfers")
  `ABMS_ASSERT_NXT(a_req_advances, accept, seq == S_LOAD || rsp.valid, "request stalled")
  `ABMS_ASSERT_IMP(a_mem_on_accept, mem_req.rd || mem_req.wr, accept, "stray store access")
  `ABMS_ASSERT_IMP(a_dir_exclusive, 1'b1, !(w_rdy_q && r_vld_q), "read and write overlap")

endmodule

// ===== sv/abms_ram.sv =====
// Generic single-port RAM with registered read.
module abms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/abms_mem.sv =====
// Byte store as eight byte-wide banks; steers unaligned beats onto the lanes.
module abms_mem import abms_pkg::*; (
  input  logic        clk,
  input  mem_req_t    req,
  input  logic [1:0]  size,
  output logic [63:0] rdata
);

  logic [127:0] wd2;
  logic [63:0]  wlane;
  logic [15:0]  st2;
  logic [7:0]   wstrb;
  logic [63:0]  flat;
  logic [127:0] rd2;
  logic [63:0]  rot;
  logic [7:0]   keep;
  logic         rd_win;
  logic [2:0]   rd_lane;
  logic         bank_en;

  // Rotate the beat so byte i lands on bank (off + i) mod 8.
  assign wd2     = {req.data, req.data} << {req.off[2:0], 3'b000};
  assign wlane   = wd2[127:64];
  assign st2     = {req.strb, req.strb} << req.off[2:0];
  assign wstrb   = st2[15:8];
  assign bank_en = (req.rd || req.wr) && req.win;

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [ROW_W-1:0] row;
    logic [7:0]       q;

    // Banks below the start lane hold bytes of the next row.
    assign row = req.off[OFF_W-1:3] + ROW_W'(3'(b) < req.off[2:0]);

    abms_ram #(.WIDTH(8), .DEPTH(ROWS)) u_ram (
      .clk   (clk),
      .en    (bank_en),
      .we    (req.wr && wstrb[b]),
      .addr  (row),
      .wdata (wlane[8*b +: 8]),
      .rdata (q)
    );

    assign flat[8*b +: 8] = q;
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_win  <= req.win;
      rd_lane <= req.off[2:0];
    end
  end

  assign rd2 = {flat, flat} >> {rd_lane, 3'b000};
  assign rot = rd2[63:0];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      keep[i] = rd_win && (4'(i) < (4'd1 << size));
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rdata[8*i +: 8] = keep[i] ? rot[8*i +: 8] : 8'h00;
    end
  end

endmodule

// ===== tb/tb_axi4_burst_memory_slave.sv =====
// Self-checking testbench for the burst memory slave, with a transfer-level mirror of the slave.
module tb_axi4_burst_memory_slave import abms_pkg::*;;

  typedef struct {
    logic        aw_valid;
    logic [31:0] aw_addr;
    logic [7:0]  aw_len;
    logic        ar_valid;
    logic [31:0] ar_addr;
    logic [7:0]  ar_len;
    logic        w_valid;
    logic [63:0] w_data;
    logic [7:0]  w_strb;
    logic        r_ready;
    logic        b_ready;
  } bus_in_t;

  typedef struct {
    logic        aw_ready;
    logic        ar_ready;
    logic        w_ready;
    logic        b_valid;
    logic [1:0]  b_resp;
    logic [3:0]  b_id;
    logic        r_valid;
    logic [63:0] r_data;
    logic [1:0]  r_resp;
    logic        r_last;
  } bus_out_t;

  class slave_scoreboard;
    logic [1:0]  beat_log2;
    logic [2:0]  phase;
    logic [8:0]  beats_left;
    logic [7:0]  beat_idx;
    logic [31:0] burst_base;
    bus_out_t    drive;
    logic [7:0]  mem [MEM_BYTES];
    bit          written [MEM_BYTES];
    bus_out_t    pending_outputs [$];
    int          fails;

    function new();
      beat_log2 = BEAT_SIZE_RESET;
      phase = PH_IDLE;
      beats_left = '0;
      beat_idx = '0;
      burst_base = '0;
      drive = '{default: '0};
      drive.b_resp = RESP_OKAY;
      drive.r_resp = RESP_OKAY;
      fails = 0;
    endfunction

    // Window test on the offset from the base: borrow means below the window.
    function bit in_win(logic [31:0] a);
      logic [32:0] off;
      off = {1'b0, a} - {1'b0, MEM_BASE};
      return (a != 32'd0) && !off[32] && (off < 33'(MEM_BYTES - 8));
    endfunction

    function logic [31:0] beat_addr(logic [31:0] base, int unsigned idx);
      return base + (32'(idx) << beat_log2);
    endfunction

    function logic [63:0] load_beat(logic [31:0] a);
      logic [63:0] v;
      int unsigned off;
      v = '0;
      if (!in_win(a)) return v;
      off = a - MEM_BASE;
      for (int i = 0; i < (1 << beat_log2); i++)
        if (off + i < MEM_BYTES) v[8*i +: 8] = mem[off + i];
      return v;
    endfunction

    // All eight strobes count, whatever the beat size.
    function void store_beat(logic [31:0] a, logic [63:0] data, logic [7:0] strb);
      int unsigned off;
      if (!in_win(a)) return;
      off = a - MEM_BASE;
      for (int i = 0; i < 8; i++) begin
        if (strb[i] && off + i < MEM_BYTES) begin
          mem[off + i] = data[8*i +: 8];
          written[off + i] = 1'b1;
        end
      end
    endfunction

    // True when no beat of the burst touches a byte that was never written.
    function bit read_safe(logic [31:0] addr, logic [7:0] len);
      logic [31:0] a;
      int unsigned off;
      for (int k = 0; k <= len; k++) begin
        a = beat_addr(addr, k);
        if (in_win(a)) begin
          off = a - MEM_BASE;
          for (int i = 0; i < (1 << beat_log2); i++)
            if (off + i < MEM_BYTES && !written[off + i]) return 0;
        end
      end
      return 1;
    endfunction

    function void apply_request(bus_in_t it);
      case (phase)
        PH_RADDR: begin
          drive.ar_ready = 1'b1;
          beats_left = 9'(it.ar_len) + 9'd1;
          burst_base = it.ar_addr;
          phase = PH_RDATA;
        end
        PH_RDATA: begin
          drive.r_valid = 1'b1;
          drive.r_data = load_beat(beat_addr(burst_base, beat_idx));
          if (it.r_ready) begin
            if (beats_left != 0) beats_left--;
            if (beats_left != 0) begin
              beat_idx++;
              drive.r_last = 1'b0;
            end else begin
              drive.r_last = 1'b1;
              beat_idx = '0;
              phase = PH_IDLE;
            end
          end
        end
        PH_WADDR: begin
          drive.aw_ready = 1'b1;
          beats_left = 9'(it.aw_len) + 9'd1;
          burst_base = it.aw_addr;
          phase = PH_WDATA;
        end
        PH_WDATA: begin
          drive.w_ready = 1'b1;
          if (it.w_valid) begin
            store_beat(beat_addr(burst_base, beat_idx), it.w_data, it.w_strb);
            if (beats_left != 0) beats_left--;
            if (beats_left == 0) begin
              beat_idx = '0;
              phase = PH_WACK;
            end else begin
              beat_idx++;
            end
          end
        end
        PH_WACK: begin
          drive.b_valid = 1'b1;
          drive.b_id = BID_WRITE;
          if (it.b_ready) phase = PH_IDLE;
        end
        default: begin
          drive.aw_ready = 1'b0;
          drive.ar_ready = 1'b0;
          drive.w_ready = 1'b0;
          drive.b_valid = 1'b0;
          drive.r_valid = 1'b0;
          drive.r_last = 1'b0;
          // write address wins over read address
          phase = PH_IDLE;
          if (it.aw_valid) phase = PH_WADDR;
          else if (it.ar_valid) phase = PH_RADDR;
        end
      endcase
      pending_outputs.push_back(drive);
    endfunction

    function void match_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        fails++;
      end
    endfunction

    function void check_response(bus_out_t got);
      bus_out_t want;
      if (pending_outputs.size() == 0) begin
        $error("response transfer with no expected outputs waiting");
        fails++;
        return;
      end
      want = pending_outputs.pop_front();
      match_field("aw_ready", want.aw_ready, got.aw_ready);
      match_field("ar_ready", want.ar_ready, got.ar_ready);
      match_field("w_ready", want.w_ready, got.w_ready);
      match_field("b_valid", want.b_valid, got.b_valid);
      match_field("b_resp", want.b_resp, got.b_resp);
      match_field("b_id", want.b_id, got.b_id);
      match_field("r_valid", want.r_valid, got.r_valid);
      match_field("r_data", want.r_data, got.r_data);
      match_field("r_resp", want.r_resp, got.r_resp);
      match_field("r_last", want.r_last, got.r_last);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;

  abms_req_if req_ch ();
  abms_rsp_if rsp_ch ();

  slave_scoreboard sb;
  bit              calm;
  int unsigned     sent;
  logic [31:0]     wr_addrs [$];
  logic [7:0]      wr_lens [$];

  axi4_burst_memory_slave u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  always #10 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bus_in_t noise_item();
    bus_in_t it;
    it.aw_valid = 1'($urandom_range(0, 1));
    it.aw_addr  = $urandom;
    it.aw_len   = 8'($urandom);
    it.ar_valid = 1'($urandom_range(0, 1));
    it.ar_addr  = $urandom;
    it.ar_len   = 8'($urandom);
    it.w_valid  = 1'($urandom_range(0, 1));
    it.w_data   = {$urandom, $urandom};
    it.w_strb   = 8'($urandom);
    it.r_ready  = 1'($urandom_range(0, 1));
    it.b_ready  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic logic [31:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return $urandom;
    if (r == 2) return MEM_BASE - 32'($urandom_range(0, 16));
    if (r == 3) return MEM_BASE + 32'(MEM_BYTES) - 32'($urandom_range(1, 24));
    if (r < 7) return MEM_BASE + 32'($urandom_range(0, 511));
    return MEM_BASE + 32'(MEM_BYTES) - 32'($urandom_range(9, 520));
  endfunction

  function automatic logic [7:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) return 8'($urandom_range(0, 7));
    if (r < 19) return 8'($urandom_range(8, 31));
    return ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(32, 254));
  endfunction

  // Present one bus clock of master signals and hold it until the transfer.
  task automatic send_item(bus_in_t it);
    int unsigned g;
    g = pick_gap();
    if (g != 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.aw_valid <= it.aw_valid;
    req_ch.aw_addr  <= it.aw_addr;
    req_ch.aw_len   <= it.aw_len;
    req_ch.ar_valid <= it.ar_valid;
    req_ch.ar_addr  <= it.ar_addr;
    req_ch.ar_len   <= it.ar_len;
    req_ch.w_valid  <= it.w_valid;
    req_ch.w_data   <= it.w_data;
    req_ch.w_strb   <= it.w_strb;
    req_ch.r_ready  <= it.r_ready;
    req_ch.b_ready  <= it.b_ready;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.apply_request(it);
    sent++;
  endtask

  // One whole burst from idle back to idle, with random master-side stalls.
  task automatic run_burst(bit wr, logic [31:0] addr, logic [7:0] len, bit full_strb);
    bus_in_t it;
    it = noise_item();
    it.aw_valid = wr;
    it.ar_valid = wr ? 1'($urandom_range(0, 1)) : 1'b1;
    send_item(it);
    it = noise_item();
    if (wr) begin
      it.aw_addr = addr;
      it.aw_len  = len;
    end else begin
      it.ar_addr = addr;
      it.ar_len  = len;
    end
    send_item(it);
    while (sb.phase != PH_IDLE) begin
      it = noise_item();
      it.w_valid = ($urandom_range(0, 3) != 0);
      it.r_ready = ($urandom_range(0, 3) != 0);
      it.b_ready = ($urandom_range(0, 2) != 0);
      if (full_strb) it.w_strb = '1;
      send_item(it);
    end
  endtask

  task automatic random_burst();
    bus_in_t     it;
    logic [31:0] a;
    logic [7:0]  n;
    int          tries;
    int unsigned j;
    if ($urandom_range(0, 15) == 0) calm = !calm;
    if ($urandom_range(0, 9) == 0) begin
      it = noise_item();
      it.aw_valid = 1'b0;
      it.ar_valid = 1'b0;
      send_item(it);
      return;
    end
    if ($urandom_range(0, 1) == 1) begin
      a = pick_addr();
      n = pick_len();
      wr_addrs.push_back(a);
      wr_lens.push_back(n);
      if (wr_addrs.size() > 16) begin
        void'(wr_addrs.pop_front());
        void'(wr_lens.pop_front());
      end
      run_burst(1'b1, a, n, $urandom_range(0, 2) != 0);
    end else begin
      // Aim reads at recent writes; fall back to address zero if nothing safe turns up.
      for (tries = 0; tries < 24; tries++) begin
        if (wr_addrs.size() != 0 && $urandom_range(0, 4) < 3) begin
          j = $urandom_range(0, wr_addrs.size() - 1);
          a = wr_addrs[j] + 32'($urandom_range(0, 8));
          n = 8'($urandom_range(0, wr_lens[j]));
        end else begin
          a = pick_addr();
          n = pick_len();
        end
        if (sb.read_safe(a, n)) break;
      end
      if (tries == 24) a = 32'd0;
      run_burst(1'b0, a, n, 1'b0);
    end
  endtask

  // Write the beat size only with the slave idle and every output checked.
  task automatic set_beat_size(logic [1:0] sz);
    req_ch.valid <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.beat_log2 = sz;
  endtask

  initial begin : rsp_pace
    int unsigned hold;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        hold = pick_gap();
        rsp_ch.ready <= (hold == 0);
      end
    end
  end

  initial begin : rsp_watch
    bus_out_t got;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got.aw_ready = rsp_ch.aw_ready;
        got.ar_ready = rsp_ch.ar_ready;
        got.w_ready  = rsp_ch.w_ready;
        got.b_valid  = rsp_ch.b_valid;
        got.b_resp   = rsp_ch.b_resp;
        got.b_id     = rsp_ch.b_id;
        got.r_valid  = rsp_ch.r_valid;
        got.r_data   = rsp_ch.r_data;
        got.r_resp   = rsp_ch.r_resp;
        got.r_last   = rsp_ch.r_last;
        sb.check_response(got);
      end
    end
  end

  initial begin
    #20000000;
    $display("tb_axi4_burst_memory_slave NOT OK");
    $finish;
  end

  initial begin
    logic [1:0]  size_order [4];
    int unsigned target;
    size_order = '{2'd0, 2'd2, 2'd1, 2'd3};
    sb = new();
    calm = 1'b0;
    sent = 0;
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.aw_valid <= 1'b0;
    req_ch.aw_addr  <= '0;
    req_ch.aw_len   <= '0;
    req_ch.ar_valid <= 1'b0;
    req_ch.ar_addr  <= '0;
    req_ch.ar_len   <= '0;
    req_ch.w_valid  <= 1'b0;
    req_ch.w_data   <= '0;
    req_ch.w_strb   <= '0;
    req_ch.r_ready  <= 1'b0;
    req_ch.b_ready  <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_beat_size(BEAT_SIZE_RESET);
    // bottom of the window, then the last full beat below the top edge
    run_burst(1'b1, MEM_BASE, 8'd3, 1'b1);
    run_burst(1'b1, MEM_BASE + 32'(MEM_BYTES) - 32'd17, 8'd1, 1'b1);
    // third beat runs past the window and reads zero
    run_burst(1'b0, MEM_BASE + 32'(MEM_BYTES) - 32'd17, 8'd2, 1'b0);
    run_burst(1'b0, MEM_BASE, 8'd3, 1'b0);
    // address zero: write dropped, read gives zero
    run_burst(1'b1, 32'd0, 8'd0, 1'b1);
    run_burst(1'b0, 32'd0, 8'd0, 1'b0);
    // beat address wraps through zero
    run_burst(1'b0, 32'hFFFF_FFF8, 8'd1, 1'b0);

    for (int p = 0; p < 6; p++) begin
      set_beat_size(p < 4 ? size_order[p] : 2'($urandom_range(0, 3)));
      target = sent + 275;
      while (sent < target) random_burst();
    end

    req_ch.valid <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fails == 0) $display("tb_axi4_burst_memory_slave OK");
    else $display("tb_axi4_burst_memory_slave NOT OK");
    $finish;
  end

endmodule
